FILE: sv/lz5d_pkg.sv
`default_nettype none

package lz5d_pkg;

  // History ring geometry and start position.
  localparam int unsigned RING_SIZE = 4096;
  localparam int unsigned RING_AW   = $clog2(RING_SIZE);
  localparam logic [RING_AW-1:0] RING_START = RING_AW'(4078);
  localparam logic [RING_AW-1:0] RING_LAST  = RING_AW'(RING_SIZE - 1);

  // Preset pattern region boundaries.
  localparam logic [RING_AW-1:0] PRE_DIV_END  = RING_AW'(3328);
  localparam logic [RING_AW-1:0] PRE_UP_END   = RING_AW'(3584);
  localparam logic [RING_AW-1:0] PRE_DOWN_END = RING_AW'(3840);
  localparam logic [RING_AW-1:0] PRE_ZERO_END = RING_AW'(3968);
  localparam logic [7:0]         PRE_SPACE    = 8'h20;
  localparam logic [3:0]         PRE_DIVISOR_LAST = 4'd12;

  // Match encoding.
  localparam logic [4:0] MATCH_MIN = 5'd3;
  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;
    logic take_flag;
    logic take_lit;
    logic take_first;
    logic take_second;
    logic rd_issue;
    logic copy_wr;
    logic copy_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic finished;
    logic phase;
    logic flags_empty;
    logic flag_bit;
    logic out_free;
    logic last_copy;
    logic reach_done;
  } status_t;

  // Preset ring value at an address; quo is the running address divided by 13.
  function automatic logic [7:0] preset_value(input logic [RING_AW-1:0] addr,
                                              input logic [7:0] quo);
    logic [7:0] val;
    if (addr < PRE_DIV_END) begin
      val = quo;
    end else if (addr < PRE_UP_END) begin
      val = addr[7:0];
    end else if (addr < PRE_DOWN_END) begin
      val = ~addr[7:0];
    end else if (addr < PRE_ZERO_END) begin
      val = 8'd0;
    end else if (addr < RING_START) begin
      val = PRE_SPACE;
    end else begin
      val = 8'd0;
    end
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lz5d_ram.sv
`default_nettype none

module lz5d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/lz5d_dp.sv
`default_nettype none

module lz5d_dp
  import lz5d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        cfg_wr_i,
  input  wire logic [31:0] output_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             done_res_o
);

  // Control state.
  logic [RING_AW-1:0] wp_q, wp_d;
  logic [7:0]         flag_q, flag_d;
  logic [3:0]         flagcnt_q, flagcnt_d;
  logic               phase_q, phase_d;
  logic [31:0]        prod_q, prod_d;
  logic [31:0]        len_q, len_d;
  logic               out_valid_q, out_valid_d;
  logic [RING_AW-1:0] init_addr_q, init_addr_d;
  logic [7:0]         init_quo_q, init_quo_d;
  logic [3:0]         init_rem_q, init_rem_d;

  // Payload state.
  logic [7:0]         first_q, first_d;
  logic [RING_AW-1:0] pos_q, pos_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_last_q, out_last_d;
  logic               out_done_q, out_done_d;

  // Ring port signals.
  logic               ram_we;
  logic [RING_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  logic [32:0]        prod_next;
  logic               emit;
  logic               out_taken;

  lz5d_ram #(
    .WIDTH (8),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // Status toward the controller.
  assign prod_next = {1'b0, prod_q} + 33'd1;
  assign out_taken = out_valid_q && !out_stall_i;

  always_comb begin
    status_o.init_last   = (init_addr_q == RING_LAST);
    status_o.finished    = (prod_q >= len_q);
    status_o.phase       = phase_q;
    status_o.flags_empty = (flagcnt_q == 4'd0);
    status_o.flag_bit    = flag_q[0];
    status_o.out_free    = !out_valid_q || !out_stall_i;
    status_o.last_copy   = (cnt_q == 5'd1);
    status_o.reach_done  = (prod_next >= {1'b0, len_q});
  end

  // Ring write port: preset sweep, literal, or match copy.
  assign emit = cmd_i.take_lit || cmd_i.copy_wr;

  always_comb begin
    ram_we    = cmd_i.init_wr || emit;
    ram_waddr = wp_q;
    ram_wdata = cmd_i.take_lit ? in_byte_i : ram_rdata;
    if (cmd_i.init_wr) begin
      ram_waddr = init_addr_q;
      ram_wdata = preset_value(init_addr_q, init_quo_q);
    end
  end

  // Next-state logic for the parser, counters and output word.
  always_comb begin
    wp_d        = wp_q;
    flag_d      = flag_q;
    flagcnt_d   = flagcnt_q;
    phase_d     = phase_q;
    prod_d      = prod_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    init_addr_d = init_addr_q;
    init_quo_d  = init_quo_q;
    init_rem_d  = init_rem_q;
    first_d     = first_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;

    if (cfg_wr_i) begin
      len_d = output_length_i;
    end

    // Preset sweep keeps a running quotient and remainder by 13.
    if (cmd_i.init_wr) begin
      init_addr_d = init_addr_q + RING_AW'(1);
      if (init_rem_q == PRE_DIVISOR_LAST) begin
        init_rem_d = 4'd0;
        init_quo_d = init_quo_q + 8'd1;
      end else begin
        init_rem_d = init_rem_q + 4'd1;
      end
    end

    if (cmd_i.take_flag) begin
      flag_d    = in_byte_i;
      flagcnt_d = FLAGS_PER_BYTE;
    end

    if (cmd_i.take_lit || cmd_i.take_first) begin
      flag_d    = {1'b0, flag_q[7:1]};
      flagcnt_d = flagcnt_q - 4'd1;
    end

    if (cmd_i.take_first) begin
      first_d = in_byte_i;
      phase_d = 1'b1;
    end

    if (cmd_i.take_second) begin
      phase_d = 1'b0;
      pos_d   = {in_byte_i[7:4], first_q};
      cnt_d   = {1'b0, in_byte_i[3:0]} + MATCH_MIN;
    end

    if (cmd_i.rd_issue) begin
      pos_d = pos_q + RING_AW'(1);
    end

    if (out_taken) begin
      out_valid_d = 1'b0;
    end

    // One decoded byte goes to the ring and the output word.
    if (emit) begin
      wp_d        = wp_q + RING_AW'(1);
      prod_d      = prod_next[31:0];
      out_valid_d = 1'b1;
      out_byte_d  = ram_wdata;
      out_done_d  = status_o.reach_done;
      out_last_d  = cmd_i.take_lit || cmd_i.copy_last;
    end

    if (cmd_i.copy_wr) begin
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= RING_START;
      flag_q      <= 8'd0;
      flagcnt_q   <= 4'd0;
      phase_q     <= 1'b0;
      prod_q      <= 32'd0;
      len_q       <= 32'd0;
      out_valid_q <= 1'b0;
      init_addr_q <= '0;
      init_quo_q  <= 8'd0;
      init_rem_q  <= 4'd0;
    end else begin
      wp_q        <= wp_d;
      flag_q      <= flag_d;
      flagcnt_q   <= flagcnt_d;
      phase_q     <= phase_d;
      prod_q      <= prod_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      init_addr_q <= init_addr_d;
      init_quo_q  <= init_quo_d;
      init_rem_q  <= init_rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;
  assign done_res_o  = out_done_q;

endmodule

`default_nettype wire

FILE: sv/lz5d_ctrl.sv
`default_nettype none

module lz5d_ctrl
  import lz5d_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_MREAD,
    ST_MWRITE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Input words are taken only while idle and the output word can move.
  assign in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !status_i.finished) begin
          if (status_i.phase) begin
            cmd_o.take_second = 1'b1;
            state_d = ST_MREAD;
          end else if (status_i.flags_empty) begin
            cmd_o.take_flag = 1'b1;
          end else if (status_i.flag_bit) begin
            cmd_o.take_lit = 1'b1;
          end else begin
            cmd_o.take_first = 1'b1;
          end
        end
      end
      ST_MREAD: begin
        // Issue the ring read once the output word will be free for its result.
        if (status_i.out_free) begin
          cmd_o.rd_issue = 1'b1;
          state_d = ST_MWRITE;
        end
      end
      ST_MWRITE: begin
        cmd_o.copy_wr   = 1'b1;
        cmd_o.copy_last = status_i.last_copy || status_i.reach_done;
        state_d = cmd_o.copy_last ? ST_IDLE : ST_MREAD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lzss_lz5_decompressor.sv
// Channel  Direction  Handshake            Word
// in       input      in_valid_i/in_stall_o  in_byte_i
// out      output     out_valid_o/out_stall_i out_byte_o, run_last_o, done_res_o
// cfg      input      cfg_valid_i/cfg_ready_o output_length_i
//
// A flag byte, a literal and the first byte of a match are each handled in ST_IDLE.
// The second byte of a match starts the copy; every copied byte is read from the ring
// through its registered read port (ST_MREAD) and then written (ST_MWRITE).
// After reset the ring is preset in a sweep over all 4096 addresses with in_stall_o held high.
// A stalled output word holds input and copying until it is taken.
`default_nettype none

module lzss_lz5_decompressor
  import lz5d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             done_res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] output_length_i
);

  cmd_t    cmd;
  status_t status;

  // The length register can always take a word.
  assign cfg_ready_o = 1'b1;

  lz5d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lz5d_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_byte_i       (in_byte_i),
    .cfg_wr_i        (cfg_valid_i && cfg_ready_o),
    .output_length_i (output_length_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .run_last_o      (run_last_o),
    .done_res_o      (done_res_o)
  );

endmodule

`default_nettype wire

FILE: sv/lz5d_checker.sv
`default_nettype none

module lz5d_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_last_o,
  input wire logic       done_res_o
);

  // No input word is taken in the first cycle after reset, while the ring is preset.
  a_stall_in_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_stall_o)
    else $error("input accepted right after reset");

  // A stalled output word holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(done_res_o))
    else $error("stalled output word changed");

  // A stalled output word blocks the input side.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted behind a stalled output word");

  // The byte that reaches the length also ends its run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> run_last_o)
    else $error("done byte without run end");

  // Nothing follows directly after the done byte.
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && done_res_o |=> !out_valid_o)
    else $error("output after done byte");

endmodule

bind lzss_lz5_decompressor lz5d_checker u_lz5d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .run_last_o  (run_last_o),
  .done_res_o  (done_res_o)
);

`default_nettype wire
